// File: rtl/core/cmcu_pkg.sv
// Shared types and constants for the count-min heavy-hitter block.
`timescale 1ns / 1ps

package cmcu_pkg;

  // Port field widths.
  localparam int KIND_W = 1;
  localparam int SLOT_W = 7;
  localparam int SEED_W = 14;
  localparam int KEY_W  = 32;
  localparam int EST_W  = 32;
  localparam int THR_W  = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(145);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_SEED = 1'b0;
  localparam logic [KIND_W-1:0] KIND_KEY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_MIN,
    ST_UPDATE
  } state_t;

endpackage

// File: rtl/core/cmcu_in_if.sv
// Input channel: seed writes and keys.
`timescale 1ns / 1ps

interface cmcu_in_if;
  logic                       valid;
  logic                       ready;
  logic [cmcu_pkg::KIND_W-1:0] kind;
  logic [cmcu_pkg::SLOT_W-1:0] seed_index;
  logic [cmcu_pkg::SEED_W-1:0] seed_value;
  logic [cmcu_pkg::KEY_W-1:0]  key;

  modport source (output valid, kind, seed_index, seed_value, key, input ready);
  modport sink (input valid, kind, seed_index, seed_value, key, output ready);
endinterface

// File: rtl/core/cmcu_out_if.sv
// Result channel: key, estimate and heavy flag.
`timescale 1ns / 1ps

interface cmcu_out_if;
  logic                       valid;
  logic                       ready;
  logic [cmcu_pkg::KEY_W-1:0] key_out;
  logic [cmcu_pkg::EST_W-1:0] estimate;
  logic                       heavy;

  modport source (output valid, key_out, estimate, heavy, input ready);
  modport sink (input valid, key_out, estimate, heavy, output ready);
endinterface

// File: rtl/core/count_min_cu_heavy_hitter.sv
// Count-min heavy-hitter counter with conservative update.
//
// Channels: items (valid/ready) carries either a seed write (kind 0: one
// 14-bit hash seed into slot seed_index) or a key (kind 1). results
// (valid/ready) carries one transaction per key: the key, the estimate
// (minimum of the row counters before the update) and the heavy flag.
// cfg_wr_en/cfg_wr_data write the heavy threshold, reset 145.
//
// Flow: a seed write is taken in the idle state and leaves it idle. A key
// runs from acceptance through hash, counter read (registered memory read),
// minimum, then write-back and result load; no item is taken until it is
// done. Each row has its own counter bank, so all rows are read and written
// in parallel. The result is registered at the write-back.
//
// Reset: threshold and seeds are set at once; the counter banks are then
// cleared one address per cycle across all rows, all 2^INDEX_BITS of them,
// during which items is not ready. Configuration writes are always taken.
// Stall: a result waits in the output register; the next item can still be
// accepted and worked on up to the write-back, which holds until the
// result register is free.
`timescale 1ns / 1ps

module count_min_cu_heavy_hitter #(
  parameter int ROWS         = 4,
  parameter int INDEX_BITS   = 14,
  parameter int KEY_BITS     = 32,
  parameter int COUNTER_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  cmcu_in_if.sink                     items,
  cmcu_out_if.source                  results,
  input  logic                        cfg_wr_en,
  input  logic [cmcu_pkg::THR_W-1:0]  cfg_wr_data
);

  cmcu_pkg::state_t state, state_next;

  logic [cmcu_pkg::THR_W-1:0] threshold;
  logic [INDEX_BITS-1:0]      clr_cnt;
  logic [KEY_BITS-1:0]        key_reg;
  logic [COUNTER_BITS-1:0]    min_reg;
  logic [COUNTER_BITS-1:0]    min_next;
  logic [INDEX_BITS-1:0]      row_addr [ROWS];
  logic [COUNTER_BITS-1:0]    row_data [ROWS];

  logic in_ready;
  logic rd_en;
  logic clearing;
  logic upd_go;
  logic out_valid;
  logic out_free;
  logic accept;
  logic seed_wr;
  logic clr_done;
  logic min_sat;
  logic [COUNTER_BITS-1:0]       min_inc;
  logic [cmcu_pkg::EST_W:0]      est_inc;
  logic                          heavy_next;

  assign accept   = items.valid && in_ready;
  assign seed_wr  = accept && (items.kind == cmcu_pkg::KIND_SEED);
  assign out_free = !out_valid || results.ready;
  assign clr_done = &clr_cnt;
  assign min_sat  = &min_reg;
  assign min_inc  = min_reg + COUNTER_BITS'(1);

  // estimate + 1 at one bit wider than the estimate, so it cannot wrap
  assign est_inc    = {1'b0, cmcu_pkg::EST_W'(min_reg)} + (cmcu_pkg::EST_W + 1)'(1);
  assign heavy_next = est_inc >= {1'b0, threshold};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cmcu_pkg::ST_CLEAR: begin
        if (clr_done) begin
          state_next = cmcu_pkg::ST_IDLE;
        end
      end
      cmcu_pkg::ST_IDLE: begin
        if (accept && items.kind == cmcu_pkg::KIND_KEY) begin
          state_next = cmcu_pkg::ST_HASH;
        end
      end
      cmcu_pkg::ST_HASH:   state_next = cmcu_pkg::ST_READ;
      cmcu_pkg::ST_READ:   state_next = cmcu_pkg::ST_MIN;
      cmcu_pkg::ST_MIN:    state_next = cmcu_pkg::ST_UPDATE;
      cmcu_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_next = cmcu_pkg::ST_IDLE;
        end
      end
      default: state_next = cmcu_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    clearing = 1'b0;
    upd_go   = 1'b0;
    unique case (state)
      cmcu_pkg::ST_CLEAR:  clearing = 1'b1;
      cmcu_pkg::ST_IDLE:   in_ready = 1'b1;
      cmcu_pkg::ST_HASH:   ;
      cmcu_pkg::ST_READ:   rd_en    = 1'b1;
      cmcu_pkg::ST_MIN:    ;
      cmcu_pkg::ST_UPDATE: upd_go   = out_free;
      default:             ;
    endcase
  end

  assign items.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cmcu_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      threshold <= cmcu_pkg::THR_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + INDEX_BITS'(1);
      end
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (upd_go) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_reg <= items.key[KEY_BITS-1:0];
    end
  end

  cmcu_hash #(
    .ROWS       (ROWS),
    .INDEX_BITS (INDEX_BITS),
    .KEY_BITS   (KEY_BITS)
  ) u_hash (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (seed_wr),
    .wr_slot  (items.seed_index),
    .wr_value (items.seed_value),
    .key      (key_reg),
    .addr     (row_addr)
  );

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic                    wr_en;
    logic [INDEX_BITS-1:0]   wr_addr;
    logic [COUNTER_BITS-1:0] wr_data;

    // conservative update: only counters sitting at the minimum move
    assign wr_en   = clearing || (upd_go && !min_sat && row_data[r] == min_reg);
    assign wr_addr = clearing ? clr_cnt : row_addr[r];
    assign wr_data = clearing ? '0 : min_inc;

    cmcu_bank #(
      .ADDR_BITS (INDEX_BITS),
      .DATA_BITS (COUNTER_BITS)
    ) u_bank (
      .clk     (clk),
      .rd_en   (rd_en),
      .rd_addr (row_addr[r]),
      .rd_data (row_data[r]),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
    );
  end

  always_comb begin
    min_next = row_data[0];
    for (int r = 1; r < ROWS; r++) begin
      if (row_data[r] < min_next) begin
        min_next = row_data[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == cmcu_pkg::ST_MIN) begin
      min_reg <= min_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      results.key_out  <= cmcu_pkg::KEY_W'(key_reg);
      results.estimate <= cmcu_pkg::EST_W'(min_reg);
      results.heavy    <= heavy_next;
    end
  end

  assign results.valid = out_valid;

endmodule

// File: rtl/core/cmcu_bank.sv
// One row of counters: single-port-write, registered-read memory.
`timescale 1ns / 1ps

module cmcu_bank #(
  parameter int ADDR_BITS = 14,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/cmcu_hash.sv
// H3 seed store and per-row hash, registered row addresses.
`timescale 1ns / 1ps

module cmcu_hash #(
  parameter int ROWS       = 4,
  parameter int INDEX_BITS = 14,
  parameter int KEY_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [cmcu_pkg::SLOT_W-1:0]   wr_slot,
  input  logic [cmcu_pkg::SEED_W-1:0]   wr_value,
  input  logic [KEY_BITS-1:0]           key,
  output logic [INDEX_BITS-1:0]         addr [ROWS]
);

  localparam int SLOTS  = ROWS * KEY_BITS;
  localparam int SIDX_W = $clog2(SLOTS);

  logic [INDEX_BITS-1:0] seeds [SLOTS];
  logic [INDEX_BITS-1:0] hash  [ROWS];
  logic                  slot_ok;

  assign slot_ok = 32'(wr_slot) < 32'(SLOTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        seeds[s] <= '0;
      end
    end else if (wr_en && slot_ok) begin
      seeds[SIDX_W'(wr_slot)] <= INDEX_BITS'(wr_value);
    end
  end

  // Seed i of a row joins the XOR when key bit (KEY_BITS-1-i) is clear.
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      hash[r] = '0;
      for (int i = 0; i < KEY_BITS; i++) begin
        if (!key[KEY_BITS-1-i]) begin
          hash[r] = hash[r] ^ seeds[r*KEY_BITS + i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < ROWS; r++) begin
      addr[r] <= hash[r];
    end
  end

endmodule

// File: rtl/core/cmcu_checker.sv
// Port-level checks for the count-min heavy-hitter block, bound to the top.
`timescale 1ns / 1ps

module cmcu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [cmcu_pkg::KIND_W-1:0] in_kind,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [cmcu_pkg::KEY_W-1:0] key_out,
  input logic [cmcu_pkg::EST_W-1:0] estimate,
  input logic                       heavy
);

  // counters are being cleared straight after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready && !res_valid)
    else $error("item taken or result shown during counter clear");

  // keys are handled one at a time
  a_key_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == cmcu_pkg::KIND_KEY |=> !in_ready)
    else $error("item taken while a key is in progress");

  // a seed write never raises a result
  a_seed_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == cmcu_pkg::KIND_SEED && !res_valid |=> !res_valid)
    else $error("result after a seed write");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      res_valid && $stable(key_out) && $stable(estimate) && $stable(heavy))
    else $error("stalled result changed");

endmodule

bind count_min_cu_heavy_hitter cmcu_checker u_cmcu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_kind   (items.kind),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .key_out   (results.key_out),
  .estimate  (results.estimate),
  .heavy     (results.heavy)
);

// File: tb/sv/tb_count_min_cu_heavy_hitter.sv
// Self-checking testbench for the count-min heavy-hitter block.
`timescale 1ns / 1ps

module tb_count_min_cu_heavy_hitter;

  localparam int N_ROWS    = 4;
  localparam int ROW_BITS  = 14;
  localparam int N_SLOTS   = 128;
  localparam int SETTLE_CY = 10;

  typedef struct {
    logic [cmcu_pkg::KEY_W-1:0] key;
    logic [cmcu_pkg::EST_W-1:0] estimate;
    logic                       heavy;
  } tally_t;

  // Predicts the estimate and heavy flag of every key from its own copy of
  // the seeds, counters and threshold.
  class cm_tally_predictor;
    bit [cmcu_pkg::SEED_W-1:0] seeds [N_SLOTS];
    bit [cmcu_pkg::EST_W-1:0]  counters [N_ROWS][1 << ROW_BITS];
    bit [cmcu_pkg::THR_W-1:0]  threshold = cmcu_pkg::THR_RESET;
    tally_t                    expected_tallies [$];
    int                        mismatches = 0;

    function bit [ROW_BITS-1:0] row_index(int row, logic [cmcu_pkg::KEY_W-1:0] key);
      bit [ROW_BITS-1:0] h;
      h = '0;
      // seed i of a row joins the XOR when key bit 31-i is clear
      for (int i = 0; i < cmcu_pkg::KEY_W; i++)
        if (!key[cmcu_pkg::KEY_W-1-i]) h ^= seeds[row*cmcu_pkg::KEY_W + i][ROW_BITS-1:0];
      return h;
    endfunction

    function void count_item(logic [cmcu_pkg::KIND_W-1:0] kind,
                             logic [cmcu_pkg::SLOT_W-1:0] slot,
                             logic [cmcu_pkg::SEED_W-1:0] value,
                             logic [cmcu_pkg::KEY_W-1:0]  key);
      bit [ROW_BITS-1:0]        addr [N_ROWS];
      bit [cmcu_pkg::EST_W-1:0] floor_val;
      tally_t                   t;
      if (kind == cmcu_pkg::KIND_SEED) begin
        seeds[slot] = value;
        return;
      end
      floor_val = '1;
      for (int r = 0; r < N_ROWS; r++) begin
        addr[r] = row_index(r, key);
        if (counters[r][addr[r]] < floor_val) floor_val = counters[r][addr[r]];
      end
      // conservative update: only the counters sitting at the minimum move
      for (int r = 0; r < N_ROWS; r++)
        if (counters[r][addr[r]] == floor_val && floor_val != '1)
          counters[r][addr[r]] = floor_val + cmcu_pkg::EST_W'(1);
      t.key      = key;
      t.estimate = floor_val;
      t.heavy    = ({1'b0, floor_val} + 33'd1) >= {1'b0, threshold};
      expected_tallies.push_back(t);
    endfunction

    function void check_tally(logic [cmcu_pkg::KEY_W-1:0] key,
                              logic [cmcu_pkg::EST_W-1:0] est, logic heavy);
      tally_t t;
      if (expected_tallies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: key %h estimate %0d heavy %b", key, est, heavy);
        return;
      end
      t = expected_tallies.pop_front();
      if (key !== t.key || est !== t.estimate || heavy !== t.heavy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result: key %h estimate %0d heavy %b, expected key %h estimate %0d heavy %b",
                   key, est, heavy, t.key, t.estimate, t.heavy);
      end
    endfunction

    function int outstanding();
      return expected_tallies.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [cmcu_pkg::THR_W-1:0] cfg_wr_data;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  cm_tally_predictor tally_pred = new();

  cmcu_in_if  items_ch ();
  cmcu_out_if results_ch ();

  count_min_cu_heavy_hitter dut (
    .clk         (clk),
    .rst         (rst),
    .items       (items_ch),
    .results     (results_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(10_000_000);
    $display("count_min_cu_heavy_hitter: mismatch");
    $finish;
  end

  // result side: check each transaction, then choose next cycle's ready
  always @(posedge clk) begin
    if (!rst && results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
      tally_pred.check_tally(results_ch.key_out, results_ch.estimate, results_ch.heavy);
    results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(logic [cmcu_pkg::KIND_W-1:0] kind,
                           logic [cmcu_pkg::SLOT_W-1:0] slot,
                           logic [cmcu_pkg::SEED_W-1:0] value,
                           logic [cmcu_pkg::KEY_W-1:0]  key);
    while ($urandom_range(99) < send_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid      <= 1'b1;
    items_ch.kind       <= kind;
    items_ch.seed_index <= slot;
    items_ch.seed_value <= value;
    items_ch.key        <= key;
    @(posedge clk);
    while (items_ch.ready !== 1'b1) @(posedge clk);
    tally_pred.count_item(kind, slot, value, key);
  endtask

  task automatic send_key(logic [cmcu_pkg::KEY_W-1:0] key);
    send_item(cmcu_pkg::KIND_KEY, cmcu_pkg::SLOT_W'($urandom),
              cmcu_pkg::SEED_W'($urandom), key);
  endtask

  // hold the sender until every result is in; seed writes have no result,
  // so wait further for the pipeline to drain them
  task automatic settle_block();
    items_ch.valid <= 1'b0;
    while (tally_pred.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CY) @(posedge clk);
  endtask

  task automatic set_threshold(logic [cmcu_pkg::THR_W-1:0] value);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    tally_pred.threshold = value;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(int n_items, int idle_pct, int stall_pct,
                           logic [cmcu_pkg::THR_W-1:0] thr, bit hold_midway);
    logic [cmcu_pkg::KEY_W-1:0] pool [16];
    bit                         narrow_seeds;
    int                         sent;
    int                         pick;
    set_threshold(thr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    // narrow seeds squeeze keys onto 16 counters per row, so rows disagree
    narrow_seeds = 1'($urandom_range(1));
    foreach (pool[i]) pool[i] = $urandom;
    sent = 0;
    while (sent < n_items) begin
      if (hold_midway && sent == n_items / 2) settle_block();
      pick = $urandom_range(99);
      if (pick < 8)
        send_item(cmcu_pkg::KIND_SEED, cmcu_pkg::SLOT_W'($urandom_range(N_SLOTS - 1)),
                  narrow_seeds ? cmcu_pkg::SEED_W'($urandom_range(15))
                               : cmcu_pkg::SEED_W'($urandom),
                  $urandom);
      else if (pick < 75)
        send_key(pool[$urandom_range(15)]);
      else if (pick < 85)
        send_key(pool[$urandom_range(15)] ^ (32'h1 << $urandom_range(31)));
      else
        send_key($urandom);
      sent++;
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    items_ch.valid      = 1'b0;
    items_ch.kind       = cmcu_pkg::KIND_SEED;
    items_ch.seed_index = '0;
    items_ch.seed_value = '0;
    items_ch.key        = '0;
    results_ch.ready    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all seeds zero after reset: every key hits counter 0 of each row
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    send_item(cmcu_pkg::KIND_SEED, 7'd0,   14'h3FFF, 32'hFFFF_FFFF);
    send_item(cmcu_pkg::KIND_SEED, 7'd127, 14'h2AAA, 32'h0000_0000);
    send_item(cmcu_pkg::KIND_SEED, 7'd31,  14'h1555, 32'h0000_0000);
    send_item(cmcu_pkg::KIND_SEED, 7'd64,  14'h0001, 32'h0000_0000);
    send_item(cmcu_pkg::KIND_SEED, 7'd40,  14'h0000, 32'h0000_0000);
    // rows now split: only some counters sit at the minimum
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h8000_0000);
    send_key(32'h0000_0001);
    send_key(32'h7FFF_FFFE);
    set_threshold(32'd1);
    send_key(32'h0000_0000);
    send_key(32'h0000_0000);
    // threshold zero flags everything
    set_threshold(32'd0);
    send_key(32'hFFFF_FFFF);
    set_threshold(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    send_key(32'h8000_0000);

    run_phase(300, 0,  0,  cmcu_pkg::THR_W'($urandom_range(1, 20)), 1'b0);
    run_phase(300, 53, 0,  cmcu_pkg::THR_RESET, 1'b1);
    run_phase(300, 0,  53, cmcu_pkg::THR_W'($urandom_range(20, 200)), 1'b0);
    run_phase(300, 15, 15, cmcu_pkg::THR_W'($urandom), 1'b0);

    settle_block();
    repeat (SETTLE_CY) @(posedge clk);
    if (tally_pred.mismatches == 0 && tally_pred.outstanding() == 0)
      $display("count_min_cu_heavy_hitter: match");
    else
      $display("count_min_cu_heavy_hitter: mismatch");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/cmcu_pkg.sv
rtl/core/cmcu_in_if.sv
rtl/core/cmcu_out_if.sv
rtl/core/cmcu_bank.sv
rtl/core/cmcu_hash.sv
rtl/core/count_min_cu_heavy_hitter.sv
rtl/core/cmcu_checker.sv
tb/sv/tb_count_min_cu_heavy_hitter.sv
